[hw/rtl/keypad_intruder_alarm_controller_assert.svh]
// assertion macros for the keypad intruder alarm controller
// no dependencies; included by the modules that carry assertions
`ifndef KEYPAD_INTRUDER_ALARM_CONTROLLER_ASSERT_SVH
`define KEYPAD_INTRUDER_ALARM_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define KIAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad alarm assertion failed");

// next-cycle implication, disabled while reset is held
`define KIAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad alarm assertion failed");

`endif

[hw/rtl/kiac_pkg.sv]
// shared types and constants for the keypad intruder alarm controller
// no dependencies
`timescale 1ns / 1ps

package kiac_pkg;

  // code entry
  localparam int CODE_KEYS   = 4;
  localparam int KEY_CNT_W   = $clog2(CODE_KEYS + 1);
  localparam int KEY_W       = 4;
  localparam int CODE_W      = 16;
  localparam int TIMER_W     = 24;

  localparam logic [KEY_W-1:0] KEY_B = 4'd11;
  localparam logic [KEY_W-1:0] KEY_C = 4'd12;

  // register reset values
  localparam logic [CODE_W-1:0]  USER_CODE_RST   = 16'h1234;
  localparam logic [TIMER_W-1:0] EXIT_TICKS_RST  = 24'd60000;
  localparam logic [TIMER_W-1:0] ENTRY_TICKS_RST = 24'd120000;
  localparam logic [TIMER_W-1:0] SOUND_TICKS_RST = 24'd10000;
  localparam logic [TIMER_W-1:0] BLINK_TICKS_RST = 24'd250;

  // register indexes
  typedef enum logic [2:0] {
    REG_USER_CODE   = 3'd0,
    REG_EXIT_TICKS  = 3'd1,
    REG_ENTRY_TICKS = 3'd2,
    REG_SOUND_TICKS = 3'd3,
    REG_BLINK_TICKS = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_UNSET  = 3'd0,
    MODE_EXIT   = 3'd1,
    MODE_SET    = 3'd2,
    MODE_ENTRY  = 3'd3,
    MODE_ALARM  = 3'd4,
    MODE_REPORT = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_KEY   = 2'd1,
    OP_SENSE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_GOOD   = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ZONE_NONE  = 3'd0,
    ZONE_FULL  = 3'd2,
    ZONE_ENTRY = 3'd3,
    ZONE_CODES = 3'd5
  } zone_t;

endpackage

[hw/rtl/keypad_intruder_alarm_controller.sv]
// keypad intruder alarm controller: mode state machine, code entry, timers
// depends on kiac_pkg and keypad_intruder_alarm_controller_assert.svh
// the result register is loaded from each request as it is accepted
// throughput: one request per cycle unless a waiting result stalls it; the mode and timer update is a single pass
// from the accepted request and the state registers into the state and result registers
// in_tready drops only while a result waits and out_tready is low
// reset: synchronous, active low; mode unset, timers and attempt cleared,
// configuration registers back to their defaults
`timescale 1ns / 1ps

`include "keypad_intruder_alarm_controller_assert.svh"

module keypad_intruder_alarm_controller (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // key[3:0], entry_sensor[4], full_sensor[5], zero[7:6]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // mode[2:0], sounder[3], zone[6:4], fail_total[8:7],
                                  // keys_entered[11:9], code_verdict[13:12], zero[15:14]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int KCW = kiac_pkg::KEY_CNT_W;
  localparam int TW  = kiac_pkg::TIMER_W;
  localparam int CW  = kiac_pkg::CODE_W;
  localparam logic [KCW-1:0] KEYS_FULL = KCW'(kiac_pkg::CODE_KEYS);

  // configuration registers
  logic [CW-1:0] user_code_r;
  logic [TW-1:0] exit_ticks_r, entry_ticks_r, sound_ticks_r, blink_ticks_r;

  logic            cfg_wr;
  kiac_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = kiac_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_code_r   <= kiac_pkg::USER_CODE_RST;
      exit_ticks_r  <= kiac_pkg::EXIT_TICKS_RST;
      entry_ticks_r <= kiac_pkg::ENTRY_TICKS_RST;
      sound_ticks_r <= kiac_pkg::SOUND_TICKS_RST;
      blink_ticks_r <= kiac_pkg::BLINK_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        kiac_pkg::REG_USER_CODE:   user_code_r   <= cfg_pwdata[CW-1:0];
        kiac_pkg::REG_EXIT_TICKS:  exit_ticks_r  <= cfg_pwdata[TW-1:0];
        kiac_pkg::REG_ENTRY_TICKS: entry_ticks_r <= cfg_pwdata[TW-1:0];
        kiac_pkg::REG_SOUND_TICKS: sound_ticks_r <= cfg_pwdata[TW-1:0];
        kiac_pkg::REG_BLINK_TICKS: blink_ticks_r <= cfg_pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      kiac_pkg::REG_USER_CODE:   cfg_prdata = {{(32-CW){1'b0}}, user_code_r};
      kiac_pkg::REG_EXIT_TICKS:  cfg_prdata = {{(32-TW){1'b0}}, exit_ticks_r};
      kiac_pkg::REG_ENTRY_TICKS: cfg_prdata = {{(32-TW){1'b0}}, entry_ticks_r};
      kiac_pkg::REG_SOUND_TICKS: cfg_prdata = {{(32-TW){1'b0}}, sound_ticks_r};
      kiac_pkg::REG_BLINK_TICKS: cfg_prdata = {{(32-TW){1'b0}}, blink_ticks_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // request fields
  logic                         in_accept;
  kiac_pkg::op_t                op;
  logic [kiac_pkg::KEY_W-1:0]   key;
  logic                         ent_sens, full_sens;

  assign op        = kiac_pkg::op_t'(in_tuser);
  assign key       = in_tdata[3:0];
  assign ent_sens  = in_tdata[4];
  assign full_sens = in_tdata[5];

  // state
  kiac_pkg::mode_t    mode_r, mode_nxt;
  logic [CW-1:0]      keys_r, keys_nxt;
  logic [KCW-1:0]     key_count_r, key_count_nxt;
  logic [1:0]         fail_count_r, fail_count_nxt;
  logic [2:0]         zone_r, zone_nxt;
  logic [TW-1:0]      phase_r, phase_nxt;
  logic [TW-1:0]      sound_r, sound_nxt;
  logic [TW-1:0]      blink_r, blink_nxt;
  logic               sounder_r, sounder_nxt;
  kiac_pkg::verdict_t verdict;

  // result register
  logic        out_valid_r;
  logic [15:0] out_data_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= kiac_pkg::MODE_UNSET;
      keys_r       <= '0;
      key_count_r  <= '0;
      fail_count_r <= '0;
      zone_r       <= '0;
      phase_r      <= '0;
      sound_r      <= '0;
      blink_r      <= '0;
      sounder_r    <= 1'b0;
    end else if (in_accept) begin
      mode_r       <= mode_nxt;
      keys_r       <= keys_nxt;
      key_count_r  <= key_count_nxt;
      fail_count_r <= fail_count_nxt;
      zone_r       <= zone_nxt;
      phase_r      <= phase_nxt;
      sound_r      <= sound_nxt;
      blink_r      <= blink_nxt;
      sounder_r    <= sounder_nxt;
    end
  end

  // next state for one request
  always_comb begin
    logic good;
    logic go_alarm;
    logic [2:0] alarm_zone;
    logic go_change;
    kiac_pkg::mode_t change_mode;

    good        = (keys_r == user_code_r);
    go_alarm    = 1'b0;
    alarm_zone  = kiac_pkg::ZONE_NONE;
    go_change   = 1'b0;
    change_mode = mode_r;

    mode_nxt       = mode_r;
    keys_nxt       = keys_r;
    key_count_nxt  = key_count_r;
    fail_count_nxt = fail_count_r;
    zone_nxt       = zone_r;
    phase_nxt      = phase_r;
    sound_nxt      = sound_r;
    blink_nxt      = blink_r;
    sounder_nxt    = sounder_r;
    verdict        = kiac_pkg::VERDICT_NONE;

    unique case (op)
      kiac_pkg::OP_TICK: begin
        if (mode_r == kiac_pkg::MODE_EXIT || mode_r == kiac_pkg::MODE_ENTRY) begin
          // blink countdown, then phase countdown
          if (blink_r <= TW'(1)) begin
            sounder_nxt = ~sounder_r;
            blink_nxt   = blink_ticks_r;
          end else begin
            blink_nxt = blink_r - TW'(1);
          end
          if (phase_r <= TW'(1)) begin
            phase_nxt = '0;
            if (mode_r == kiac_pkg::MODE_EXIT) begin
              go_change   = 1'b1;
              change_mode = kiac_pkg::MODE_SET;
            end else begin
              go_alarm   = 1'b1;
              alarm_zone = kiac_pkg::ZONE_ENTRY;
            end
          end else begin
            phase_nxt = phase_r - TW'(1);
          end
        end else if (mode_r == kiac_pkg::MODE_ALARM && sound_r != '0) begin
          sound_nxt = sound_r - TW'(1);
          if (sound_r == TW'(1)) sounder_nxt = 1'b0;
        end
      end
      kiac_pkg::OP_KEY: begin
        if (mode_r == kiac_pkg::MODE_REPORT) begin
          if (key == kiac_pkg::KEY_C) begin
            go_change   = 1'b1;
            change_mode = kiac_pkg::MODE_UNSET;
            zone_nxt    = kiac_pkg::ZONE_NONE;
          end
        end else if (mode_r == kiac_pkg::MODE_UNSET || mode_r == kiac_pkg::MODE_EXIT ||
                     mode_r == kiac_pkg::MODE_ENTRY || mode_r == kiac_pkg::MODE_ALARM) begin
          if (key_count_r < KEYS_FULL) begin
            // collect or delete a key
            if (key == kiac_pkg::KEY_C) begin
              if (key_count_r != '0) begin
                key_count_nxt = key_count_r - KCW'(1);
                keys_nxt      = keys_r >> kiac_pkg::KEY_W;
              end
            end else begin
              keys_nxt      = {keys_r[CW-kiac_pkg::KEY_W-1:0], key};
              key_count_nxt = key_count_r + KCW'(1);
            end
          end else if (key == kiac_pkg::KEY_B) begin
            // code check
            keys_nxt      = '0;
            key_count_nxt = '0;
            if (good) begin
              verdict        = kiac_pkg::VERDICT_GOOD;
              fail_count_nxt = '0;
              go_change      = 1'b1;
              if (mode_r == kiac_pkg::MODE_UNSET)      change_mode = kiac_pkg::MODE_EXIT;
              else if (mode_r == kiac_pkg::MODE_ALARM) change_mode = kiac_pkg::MODE_REPORT;
              else                                     change_mode = kiac_pkg::MODE_UNSET;
            end else begin
              verdict = kiac_pkg::VERDICT_REJECT;
              if (mode_r == kiac_pkg::MODE_UNSET || mode_r == kiac_pkg::MODE_EXIT) begin
                if (fail_count_r >= 2'd2) begin
                  go_alarm   = 1'b1;
                  alarm_zone = kiac_pkg::ZONE_CODES;
                end else begin
                  fail_count_nxt = fail_count_r + 2'd1;
                end
              end
            end
          end
        end
      end
      kiac_pkg::OP_SENSE: begin
        if (mode_r == kiac_pkg::MODE_SET) begin
          if (ent_sens) begin
            go_change   = 1'b1;
            change_mode = kiac_pkg::MODE_ENTRY;
          end else if (full_sens) begin
            go_alarm   = 1'b1;
            alarm_zone = kiac_pkg::ZONE_FULL;
          end
        end else if (mode_r == kiac_pkg::MODE_EXIT || mode_r == kiac_pkg::MODE_ENTRY) begin
          if (full_sens) begin
            go_alarm   = 1'b1;
            alarm_zone = kiac_pkg::ZONE_FULL;
          end
        end
      end
      default: ;
    endcase

    // mode change: clears attempt and timers, then loads the timers that the new mode runs
    if (go_alarm) begin
      mode_nxt       = kiac_pkg::MODE_ALARM;
      keys_nxt       = '0;
      key_count_nxt  = '0;
      phase_nxt      = '0;
      blink_nxt      = '0;
      sound_nxt      = sound_ticks_r;
      sounder_nxt    = 1'b1;
      zone_nxt       = alarm_zone;
      fail_count_nxt = '0;
    end else if (go_change) begin
      mode_nxt      = change_mode;
      keys_nxt      = '0;
      key_count_nxt = '0;
      phase_nxt     = '0;
      blink_nxt     = '0;
      sound_nxt     = '0;
      unique case (change_mode)
        kiac_pkg::MODE_EXIT: begin
          phase_nxt   = exit_ticks_r;
          blink_nxt   = blink_ticks_r;
          sounder_nxt = 1'b0;
        end
        kiac_pkg::MODE_ENTRY: begin
          phase_nxt   = entry_ticks_r;
          blink_nxt   = blink_ticks_r;
          sounder_nxt = 1'b0;
        end
        kiac_pkg::MODE_REPORT: sounder_nxt = sounder_r;
        default:               sounder_nxt = 1'b0;
      endcase
    end
  end

  // result register with backpressure
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {2'b00, verdict, 3'(key_count_nxt), fail_count_nxt, zone_nxt,
                     sounder_nxt, mode_nxt};
    end
  end

  // checks
  `KIAC_ASSERT_IMPL(a_key_count_range, clk, rst_n, 1'b1, key_count_r <= KEYS_FULL)
  `KIAC_ASSERT_IMPL(a_fail_range, clk, rst_n, 1'b1, fail_count_r != 2'd3)
  `KIAC_ASSERT_NEXT(a_alarm_sounds, clk, rst_n,
    in_accept && mode_r != kiac_pkg::MODE_ALARM && mode_nxt == kiac_pkg::MODE_ALARM,
    sounder_r && sound_r == $past(sound_ticks_r))
  `KIAC_ASSERT_NEXT(a_report_holds, clk, rst_n,
    mode_r == kiac_pkg::MODE_REPORT && !(in_accept && mode_nxt != kiac_pkg::MODE_REPORT),
    $stable(sounder_r))
  `KIAC_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_r && !out_tready,
    out_valid_r && $stable(out_data_r))

endmodule
